FILE: rtl/f2dc_pkg.sv
// shared types and constants of the streaming 2d correlation filter
package f2dc_pkg;

    localparam int PIX_W        = 8;
    localparam int COEF_W       = 12;
    localparam int KMAX         = 5;
    localparam int LINE_MAX     = KMAX - 1;
    localparam int SLOT_W       = 2;
    localparam int PROD_W       = 21;
    localparam int VALUE_W      = 25;
    localparam int OUT_ROW_W    = 12;
    localparam int OUT_COL_W    = 10;
    localparam int ROW_CNT_W    = 13;
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 13;
    localparam int MAX_HEIGHT   = 4096;
    localparam int ROW_SAT      = 8191;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 60;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 3'd0,
        REG_IMAGE_HEIGHT = 3'd1,
        REG_KERNEL_ROW0  = 3'd2,
        REG_KERNEL_ROW1  = 3'd3,
        REG_KERNEL_ROW2  = 3'd4,
        REG_KERNEL_ROW3  = 3'd5,
        REG_KERNEL_ROW4  = 3'd6
    } cfg_reg_t;

    // per-item control handed from the counter stage to the datapath
    typedef struct packed {
        logic                 emit;
        logic                 last;
        logic [OUT_ROW_W-1:0] row;
        logic [OUT_COL_W-1:0] col;
        logic [PIX_W-1:0]     px;
        logic [SLOT_W-1:0]    slot;
        logic [KMAX-1:0]      rmask;
        logic [KMAX-1:0]      cmask;
    } tap_ctrl_t;

endpackage

FILE: rtl/filter2d_correlation_same_top.sv
// Streaming same-size 2D correlation with zero padding. One pixel transfer is
// taken every clock while the result side does not stall; each transfer that
// completes an output window puts one result on the output through four
// register stages (input stage with line buffer read, window/product stage,
// row sum stage, output register). Results start (KERNEL_ROWS-1)/2 rows plus
// (KERNEL_COLS-1)/2 pixels after their own position; after a frame the host
// sends drain transfers until the result marked frame_last is out. Line
// buffers need no clearing after reset.
module filter2d_correlation_same_top
    import f2dc_pkg::*;
#(
    parameter int KERNEL_ROWS = 3,
    parameter int KERNEL_COLS = 3,
    parameter int MAX_WIDTH   = 1024
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_cmd,
    input  logic [PIX_W-1:0]      s_pixel,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [VALUE_W-1:0]    m_value,
    output logic [OUT_ROW_W-1:0]  m_out_row,
    output logic [OUT_COL_W-1:0]  m_out_col,
    output logic                  m_frame_last,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int LINES = (KERNEL_ROWS > 1) ? KERNEL_ROWS - 1 : 1;

    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;
    logic [CFG_DATA_W-1:0]   kernel_reg [KMAX];

    logic                    en;
    logic                    mem_rd, mem_we;
    logic [CW-1:0]           mem_addr;
    logic [SLOT_W-1:0]       mem_wslot;
    logic [PIX_W-1:0]        mem_wdata;
    logic [PIX_W-1:0]        line_data [LINE_MAX];
    logic                    b_valid;
    tap_ctrl_t               b_ctrl;

    // whole pipeline advances unless the result register is blocked
    assign en        = !m_valid || m_ready;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_REG_W'(640);
            height_reg <= HEIGHT_REG_W'(480);
            for (int i = 0; i < KMAX; i++) begin
                kernel_reg[i] <= '0;
            end
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data[WIDTH_REG_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= cfg_data[HEIGHT_REG_W-1:0];
                REG_KERNEL_ROW0:  kernel_reg[0] <= cfg_data;
                REG_KERNEL_ROW1:  kernel_reg[1] <= cfg_data;
                REG_KERNEL_ROW2:  kernel_reg[2] <= cfg_data;
                REG_KERNEL_ROW3:  kernel_reg[3] <= cfg_data;
                REG_KERNEL_ROW4:  kernel_reg[4] <= cfg_data;
                default: ;
            endcase
        end
    end

    f2dc_ctrl #(
        .KR        (KERNEL_ROWS),
        .KC        (KERNEL_COLS),
        .MAX_WIDTH (MAX_WIDTH),
        .CW        (CW)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (en),
        .s_valid      (s_valid),
        .s_cmd        (s_cmd),
        .s_pixel      (s_pixel),
        .image_width  (width_reg),
        .image_height (height_reg),
        .mem_rd       (mem_rd),
        .mem_addr     (mem_addr),
        .mem_we       (mem_we),
        .mem_wslot    (mem_wslot),
        .mem_wdata    (mem_wdata),
        .b_valid      (b_valid),
        .b_ctrl       (b_ctrl)
    );

    // ring of line buffers holding the rows above the current one
    for (genvar j = 0; j < LINE_MAX; j++) begin : g_line
        if (KERNEL_ROWS > 1 && j < LINES) begin : g_buf
            f2dc_line_buf #(
                .DEPTH (MAX_WIDTH),
                .AW    (CW)
            ) u_buf (
                .aclk  (aclk),
                .rd_en (mem_rd),
                .addr  (mem_addr),
                .we    (mem_we && (mem_wslot == SLOT_W'(j))),
                .wdata (mem_wdata),
                .rdata (line_data[j])
            );
        end else begin : g_none
            assign line_data[j] = '0;
        end
    end

    f2dc_mac #(
        .KR (KERNEL_ROWS),
        .KC (KERNEL_COLS)
    ) u_mac (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (en),
        .b_valid      (b_valid),
        .b_ctrl       (b_ctrl),
        .line_data    (line_data),
        .kernel       (kernel_reg),
        .m_valid      (m_valid),
        .m_value      (m_value),
        .m_out_row    (m_out_row),
        .m_out_col    (m_out_col),
        .m_frame_last (m_frame_last)
    );

endmodule

FILE: rtl/f2dc_line_buf.sv
// one line buffer: single port memory with registered read before write
module f2dc_line_buf
    import f2dc_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic             aclk,
    input  logic             rd_en,
    input  logic [AW-1:0]    addr,
    input  logic             we,
    input  logic [PIX_W-1:0] wdata,
    output logic [PIX_W-1:0] rdata
);

    logic [PIX_W-1:0] mem [DEPTH];
    logic [PIX_W-1:0] rdata_reg;

    // old contents come out while the new pixel goes in
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rdata_reg <= mem[addr];
            if (we) begin
                mem[addr] <= wdata;
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/f2dc_ctrl.sv
// stream position counters, output scheduling and tap masks
module f2dc_ctrl
    import f2dc_pkg::*;
#(
    parameter int KR        = 3,
    parameter int KC        = 3,
    parameter int MAX_WIDTH = 1024,
    parameter int CW        = $clog2(MAX_WIDTH)
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    s_valid,
    input  logic                    s_cmd,
    input  logic [PIX_W-1:0]        s_pixel,
    input  logic [WIDTH_REG_W-1:0]  image_width,
    input  logic [HEIGHT_REG_W-1:0] image_height,
    output logic                    mem_rd,
    output logic [CW-1:0]           mem_addr,
    output logic                    mem_we,
    output logic [SLOT_W-1:0]       mem_wslot,
    output logic [PIX_W-1:0]        mem_wdata,
    output logic                    b_valid,
    output tap_ctrl_t               b_ctrl
);

    localparam int WW    = CW + 1;
    localparam int DW    = CW + 3;
    localparam int MIDR  = KR / 2;
    localparam int MIDC  = KC / 2;
    localparam int LOWR  = KR - 1 - MIDR;
    localparam int LOWC  = KC - 1 - MIDC;
    localparam int LINES = (KR > 1) ? KR - 1 : 1;

    logic [ROW_CNT_W-1:0] in_row_reg, in_row_next, emit_row_reg, emit_row_next;
    logic [CW-1:0]        in_col_reg, in_col_next, emit_col_reg, emit_col_next;
    logic [DW-1:0]        dist_reg, dist_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic                 b_valid_reg;
    tap_ctrl_t            b_ctrl_reg, b_ctrl_next;

    logic [WW-1:0]        w_eff;
    logic [ROW_CNT_W-1:0] h_eff;
    logic                 restart, accept, in_img, emit, last;
    logic [ROW_CNT_W-1:0] cur_in_row, cur_emit_row;
    logic [CW-1:0]        cur_in_col, cur_emit_col;
    logic [DW-1:0]        cur_dist, lag;
    logic [SLOT_W-1:0]    cur_slot;
    logic [PIX_W-1:0]     px;
    logic [KMAX-1:0]      rmask, cmask;

    // effective frame size
    always_comb begin
        if (image_width == '0) begin
            w_eff = WW'(1);
        end else if (13'(image_width) > 13'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(image_width);
        end
        if (image_height == '0) begin
            h_eff = ROW_CNT_W'(1);
        end else if (image_height > HEIGHT_REG_W'(MAX_HEIGHT)) begin
            h_eff = ROW_CNT_W'(MAX_HEIGHT);
        end else begin
            h_eff = image_height;
        end
    end

    // restart when the frame height shrank below the next output row
    assign restart      = (emit_row_reg >= h_eff);
    assign cur_in_row   = restart ? '0 : in_row_reg;
    assign cur_in_col   = restart ? '0 : in_col_reg;
    assign cur_emit_row = restart ? '0 : emit_row_reg;
    assign cur_emit_col = restart ? '0 : emit_col_reg;
    assign cur_dist     = restart ? '0 : dist_reg;
    assign cur_slot     = restart ? '0 : slot_reg;

    assign accept = s_valid & en;
    assign in_img = (cur_in_row < h_eff) && ({1'b0, cur_in_col} < w_eff);
    assign px     = s_cmd ? '0 : s_pixel;
    assign lag    = DW'(LOWR) * DW'(w_eff) + DW'(LOWC);
    assign emit   = (cur_dist >= lag);
    assign last   = emit && (cur_emit_row == h_eff - ROW_CNT_W'(1))
                    && (({1'b0, cur_emit_col} + WW'(1)) >= w_eff);

    // border masks of the taps around the output position
    always_comb begin
        int tr;
        int tc;
        rmask = '0;
        cmask = '0;
        for (int k = 0; k < KMAX; k++) begin
            tr = int'(cur_emit_row) - MIDR + k;
            tc = int'(cur_emit_col) - MIDC + k;
            if (k < KR) begin
                rmask[k] = (tr >= 0) && (tr < int'(h_eff));
            end
            if (k < KC) begin
                cmask[k] = (tc >= 0) && (tc < int'(w_eff));
            end
        end
    end

    // next counter values
    always_comb begin
        in_row_next   = cur_in_row;
        in_col_next   = cur_in_col;
        emit_row_next = cur_emit_row;
        emit_col_next = cur_emit_col;
        slot_next     = cur_slot;
        dist_next     = cur_dist + DW'(1) - DW'(emit);
        if (emit) begin
            if (({1'b0, cur_emit_col} + WW'(1)) >= w_eff) begin
                emit_col_next = '0;
                emit_row_next = cur_emit_row + ROW_CNT_W'(1);
            end else begin
                emit_col_next = cur_emit_col + CW'(1);
            end
        end
        if (last) begin
            in_row_next   = '0;
            in_col_next   = '0;
            emit_row_next = '0;
            emit_col_next = '0;
            slot_next     = '0;
            dist_next     = '0;
        end else if (({1'b0, cur_in_col} + WW'(1)) >= w_eff) begin
            in_col_next = '0;
            if (cur_in_row < ROW_CNT_W'(ROW_SAT)) begin
                in_row_next = cur_in_row + ROW_CNT_W'(1);
            end
            slot_next = (cur_slot == SLOT_W'(LINES - 1)) ? '0 : cur_slot + SLOT_W'(1);
        end else begin
            in_col_next = cur_in_col + CW'(1);
        end
    end

    always_comb begin
        b_ctrl_next.emit  = emit;
        b_ctrl_next.last  = last;
        b_ctrl_next.row   = cur_emit_row[OUT_ROW_W-1:0];
        b_ctrl_next.col   = OUT_COL_W'(cur_emit_col);
        b_ctrl_next.px    = px;
        b_ctrl_next.slot  = cur_slot;
        b_ctrl_next.rmask = rmask;
        b_ctrl_next.cmask = cmask;
    end

    // counter registers advance on every transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_row_reg   <= '0;
            in_col_reg   <= '0;
            emit_row_reg <= '0;
            emit_col_reg <= '0;
            dist_reg     <= '0;
            slot_reg     <= '0;
            b_valid_reg  <= 1'b0;
        end else begin
            if (en) begin
                b_valid_reg <= accept;
            end
            if (accept) begin
                in_row_reg   <= in_row_next;
                in_col_reg   <= in_col_next;
                emit_row_reg <= emit_row_next;
                emit_col_reg <= emit_col_next;
                dist_reg     <= dist_next;
                slot_reg     <= slot_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            b_ctrl_reg <= b_ctrl_next;
        end
    end

    assign mem_rd    = accept;
    assign mem_addr  = cur_in_col;
    assign mem_we    = accept & in_img;
    assign mem_wslot = cur_slot;
    assign mem_wdata = px;
    assign b_valid   = b_valid_reg;
    assign b_ctrl    = b_ctrl_reg;

endmodule

FILE: rtl/f2dc_mac.sv
// tap window, coefficient products and adder stages
module f2dc_mac
    import f2dc_pkg::*;
#(
    parameter int KR = 3,
    parameter int KC = 3
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  b_valid,
    input  tap_ctrl_t             b_ctrl,
    input  logic [PIX_W-1:0]      line_data [LINE_MAX],
    input  logic [CFG_DATA_W-1:0] kernel [KMAX],
    output logic                  m_valid,
    output logic [VALUE_W-1:0]    m_value,
    output logic [OUT_ROW_W-1:0]  m_out_row,
    output logic [OUT_COL_W-1:0]  m_out_col,
    output logic                  m_frame_last
);

    localparam int LINES = (KR > 1) ? KR - 1 : 1;

    logic [PIX_W-1:0]          window_reg [KR][KC];
    logic [PIX_W-1:0]          new_col [KR];
    logic [PIX_W-1:0]          shifted [KR][KC];
    logic signed [PROD_W-1:0]  prod [KR][KC];
    logic signed [PROD_W-1:0]  c_prod_reg [KR][KC];
    logic signed [VALUE_W-1:0] row_sum [KR];
    logic signed [VALUE_W-1:0] d_rsum_reg [KR];
    logic signed [VALUE_W-1:0] total;

    logic                      c_valid_reg, d_valid_reg, m_valid_reg;
    logic                      c_last_reg, d_last_reg, m_last_reg;
    logic [OUT_ROW_W-1:0]      c_row_reg, d_row_reg, m_row_reg;
    logic [OUT_COL_W-1:0]      c_col_reg, d_col_reg, m_col_reg;
    logic [VALUE_W-1:0]        m_value_reg;

    // incoming column: current pixel at the bottom, older rows from the ring
    always_comb begin
        int ph;
        for (int k = 0; k < KR; k++) begin
            ph = int'(b_ctrl.slot) - (KR - 1 - k);
            if (ph < 0) begin
                ph = ph + LINES;
            end
            if (k == KR - 1) begin
                new_col[k] = b_ctrl.px;
            end else begin
                new_col[k] = line_data[SLOT_W'(ph)];
            end
        end
    end

    // window after this transfer's shift, masked products
    always_comb begin
        for (int k = 0; k < KR; k++) begin
            for (int l = 0; l < KC; l++) begin
                if (l == KC - 1) begin
                    shifted[k][l] = new_col[k];
                end else begin
                    shifted[k][l] = window_reg[k][(l + 1) % KC];
                end
                if (b_ctrl.rmask[k] && b_ctrl.cmask[l]) begin
                    prod[k][l] = PROD_W'($signed({1'b0, shifted[k][l]})
                                 * $signed(kernel[k][COEF_W*l +: COEF_W]));
                end else begin
                    prod[k][l] = '0;
                end
            end
        end
    end

    // per-row sums, then the total
    always_comb begin
        total = '0;
        for (int k = 0; k < KR; k++) begin
            row_sum[k] = '0;
            for (int l = 0; l < KC; l++) begin
                row_sum[k] = row_sum[k] + VALUE_W'(c_prod_reg[k][l]);
            end
            total = total + d_rsum_reg[k];
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (en) begin
            if (b_valid) begin
                window_reg <= shifted;
            end
            c_prod_reg  <= prod;
            c_last_reg  <= b_ctrl.last;
            c_row_reg   <= b_ctrl.row;
            c_col_reg   <= b_ctrl.col;
            d_rsum_reg  <= row_sum;
            d_last_reg  <= c_last_reg;
            d_row_reg   <= c_row_reg;
            d_col_reg   <= c_col_reg;
            m_value_reg <= total;
            m_last_reg  <= d_last_reg;
            m_row_reg   <= d_row_reg;
            m_col_reg   <= d_col_reg;
        end
    end

    // valid flags of the stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            c_valid_reg <= b_valid & b_ctrl.emit;
            d_valid_reg <= c_valid_reg;
            m_valid_reg <= d_valid_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_value      = m_value_reg;
    assign m_out_row    = m_row_reg;
    assign m_out_col    = m_col_reg;
    assign m_frame_last = m_last_reg;

endmodule

FILE: verif/filter2d_correlation_same_top_test.sv
// testbench of the streaming same-size 2d correlation filter with zero padding
`timescale 1ns / 100ps

module filter2d_correlation_same_top_test;
    import f2dc_pkg::*;

    localparam int KR    = 3;
    localparam int KC    = 3;
    localparam int MAXW  = 1024;
    localparam int MID_R = KR / 2;
    localparam int MID_C = KC / 2;
    localparam int LOW_R = KR - 1 - MID_R;
    localparam int LOW_C = KC - 1 - MID_C;
    localparam int SLOTS = KR + LOW_C;

    typedef struct {
        logic [VALUE_W-1:0]   value;
        logic [OUT_ROW_W-1:0] row;
        logic [OUT_COL_W-1:0] col;
        logic                 last;
    } pixel_out_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_cmd;
    logic [PIX_W-1:0]      s_pixel;
    logic                  m_valid;
    logic                  m_ready;
    logic [VALUE_W-1:0]    m_value;
    logic [OUT_ROW_W-1:0]  m_out_row;
    logic [OUT_COL_W-1:0]  m_out_col;
    logic                  m_frame_last;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // shadow of the filter state
    logic [WIDTH_REG_W-1:0]  sh_width;
    logic [HEIGHT_REG_W-1:0] sh_height;
    logic [CFG_DATA_W-1:0]   sh_kernel [KMAX];
    logic [PIX_W-1:0]        sh_lines [SLOTS][MAXW];
    int unsigned             sh_tag [SLOTS];
    int unsigned             in_row, in_col, out_row_n, out_col_n;
    bit                      frame_done;

    pixel_out_t expected_pixels[$];
    int         errors;
    int         send_idle;
    int         recv_idle;

    filter2d_correlation_same_top #(
        .KERNEL_ROWS(KR),
        .KERNEL_COLS(KC),
        .MAX_WIDTH(MAXW)
    ) u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd), .s_pixel(s_pixel),
        .m_valid(m_valid), .m_ready(m_ready), .m_value(m_value),
        .m_out_row(m_out_row), .m_out_col(m_out_col), .m_frame_last(m_frame_last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // receiver back-pressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle);
    end

    function automatic int unsigned eff_width();
        if (sh_width == 0) return 1;
        if (sh_width > MAXW) return MAXW;
        return sh_width;
    endfunction

    function automatic int unsigned eff_height();
        if (sh_height == 0) return 1;
        if (sh_height > MAX_HEIGHT) return MAX_HEIGHT;
        return sh_height;
    endfunction

    function automatic void restart_frame();
        in_row = 0;
        in_col = 0;
        out_row_n = 0;
        out_col_n = 0;
        foreach (sh_tag[i]) sh_tag[i] = 0;
    endfunction

    // advance the shadow by one accepted transfer, queue the output it yields
    function automatic void correlate_step(logic cmd, logic [PIX_W-1:0] px);
        int unsigned w;
        int unsigned h;
        longint      pos_in;
        longint      pos_out;
        longint      acc;
        longint      tr;
        longint      tc;
        int unsigned slot;
        logic signed [COEF_W-1:0] cf;
        pixel_out_t  res;
        bit          last;
        w = eff_width();
        h = eff_height();
        last = 0;
        if (out_row_n >= h) restart_frame();
        if (in_row < h && in_col < w) begin
            slot = in_row % SLOTS;
            sh_lines[slot][in_col] = cmd ? '0 : px;
            sh_tag[slot] = in_row + 1;
        end
        pos_in  = longint'(in_row) * w + in_col;
        pos_out = longint'(out_row_n) * w + out_col_n;
        if (pos_in - pos_out >= longint'(LOW_R) * w + LOW_C) begin
            acc = 0;
            for (int k = 0; k < KR; k++) begin
                tr = longint'(out_row_n) - MID_R + k;
                if (tr < 0 || tr >= h) continue;
                slot = tr % SLOTS;
                for (int l = 0; l < KC; l++) begin
                    tc = longint'(out_col_n) - MID_C + l;
                    if (tc < 0 || tc >= w) continue;
                    if (sh_tag[slot] != tr + 1) continue;
                    cf = sh_kernel[k][12*l +: 12];
                    acc += longint'(sh_lines[slot][tc]) * longint'(cf);
                end
            end
            last = (out_row_n == h - 1) && (out_col_n + 1 >= w);
            res.value = acc[VALUE_W-1:0];
            res.row   = out_row_n[OUT_ROW_W-1:0];
            res.col   = out_col_n[OUT_COL_W-1:0];
            res.last  = last;
            expected_pixels.push_back(res);
            if (out_col_n + 1 >= w) begin
                out_col_n = 0;
                out_row_n++;
            end else begin
                out_col_n++;
            end
        end
        if (last) begin
            restart_frame();
            frame_done = 1;
        end else if (in_col + 1 >= w) begin
            in_col = 0;
            if (in_row < ROW_SAT) in_row++;
        end else begin
            in_col++;
        end
    endfunction

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_pixels.size() == 0) begin
                $display("%0t: unexpected output row %0d col %0d value %0d",
                         $time, m_out_row, m_out_col, $signed(m_value));
                errors++;
            end else begin
                pixel_out_t e;
                e = expected_pixels.pop_front();
                if (m_value !== e.value) begin
                    $display("%0t: value exp %0d got %0d", $time,
                             $signed(e.value), $signed(m_value));
                    errors++;
                end
                if (m_out_row !== e.row) begin
                    $display("%0t: out_row exp %0d got %0d", $time, e.row, m_out_row);
                    errors++;
                end
                if (m_out_col !== e.col) begin
                    $display("%0t: out_col exp %0d got %0d", $time, e.col, m_out_col);
                    errors++;
                end
                if (m_frame_last !== e.last) begin
                    $display("%0t: frame_last exp %0b got %0b", $time, e.last, m_frame_last);
                    errors++;
                end
            end
        end
    end

    // one pixel transfer; valid stays up for back-to-back transfers
    task automatic send_item(logic cmd, logic [PIX_W-1:0] px);
        if ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd   <= cmd;
        s_pixel <= px;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        correlate_step(cmd, px);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_pixels.size() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_IMAGE_WIDTH:  sh_width  = data[WIDTH_REG_W-1:0];
            REG_IMAGE_HEIGHT: sh_height = data[HEIGHT_REG_W-1:0];
            default:          sh_kernel[idx - REG_KERNEL_ROW0] = data;
        endcase
        @(posedge aclk);
    endtask

    task automatic set_frame(int w, int h);
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
    endtask

    task automatic random_kernel();
        write_reg(REG_KERNEL_ROW0, CFG_DATA_W'({$urandom, $urandom}));
        write_reg(REG_KERNEL_ROW1, CFG_DATA_W'({$urandom, $urandom}));
        write_reg(REG_KERNEL_ROW2, CFG_DATA_W'({$urandom, $urandom}));
        write_reg(REG_KERNEL_ROW3, CFG_DATA_W'({$urandom, $urandom}));
        write_reg(REG_KERNEL_ROW4, CFG_DATA_W'({$urandom, $urandom}));
    endtask

    // whole frame plus drain transfers until the frame's last output is predicted
    task automatic send_frame(int drain_pct);
        int n;
        n = eff_width() * eff_height();
        frame_done = 0;
        for (int i = 0; i < n; i++) begin
            send_item($urandom_range(99) < drain_pct, PIX_W'($urandom));
        end
        while (!frame_done) send_item(1'($urandom_range(1)), PIX_W'($urandom));
    endtask

    task automatic test_directed();
        // extreme coefficients and full-scale pixels
        write_reg(REG_KERNEL_ROW0, {24'h0, 12'h800, 12'h7FF, 12'h800});
        write_reg(REG_KERNEL_ROW1, {24'h0, 12'h7FF, 12'h400, 12'h001});
        write_reg(REG_KERNEL_ROW2, {24'h0, 12'hFFF, 12'h800, 12'h7FF});
        write_reg(REG_KERNEL_ROW3, '1);
        write_reg(REG_KERNEL_ROW4, '1);
        set_frame(4, 3);
        frame_done = 0;
        for (int i = 0; i < 12; i++) begin
            // drain tick inside the image stands for a zero pixel
            if (i == 5) send_item(1'b1, 8'hFF);
            else send_item(1'b0, (i % 2) ? 8'hFF : 8'h00);
        end
        // pixel during drain is dropped
        send_item(1'b0, 8'hAA);
        while (!frame_done) send_item(1'b1, 8'h55);
        wait_idle();
        // zero size registers act as one
        set_frame(0, 0);
        send_frame(0);
        wait_idle();
    endtask

    task automatic test_height_shrink();
        random_kernel();
        set_frame(5, 6);
        frame_done = 0;
        for (int i = 0; i < 17; i++) send_item(1'b0, PIX_W'($urandom));
        wait_idle();
        // next output row now lies beyond the new height
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(1));
        send_frame(0);
        wait_idle();
    endtask

    task automatic test_size_extremes();
        random_kernel();
        // oversized height register, cut short by a height shrink
        set_frame(1, 8191);
        frame_done = 0;
        for (int i = 0; i < 20; i++) send_item(1'b0, PIX_W'($urandom));
        wait_idle();
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(1));
        send_frame(3);
        wait_idle();
        // wide rows
        set_frame(64, 2);
        send_frame(3);
        wait_idle();
    endtask

    task automatic test_random(int items);
        int sent;
        sent = 0;
        while (sent < items) begin
            random_kernel();
            set_frame($urandom_range(1, 16), $urandom_range(1, 10));
            send_frame(5);
            sent += eff_width() * eff_height();
            wait_idle();
        end
    endtask

    initial begin
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_cmd     <= 1'b0;
        s_pixel   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_IMAGE_WIDTH;
        cfg_data  <= '0;
        m_ready   <= 1'b0;
        errors    = 0;
        send_idle = 23;
        recv_idle = 55;
        sh_width  = 640;
        sh_height = 480;
        foreach (sh_kernel[i]) sh_kernel[i] = '0;
        foreach (sh_lines[i, j]) sh_lines[i][j] = '0;
        restart_frame();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_height_shrink();
        test_random(450);
        send_idle = 55;
        recv_idle = 23;
        test_size_extremes();
        test_random(450);
        send_idle = 0;
        recv_idle = 0;
        test_random(450);

        wait_idle();
        if (errors == 0) begin
            $display("filter2d_correlation_same_top_test: PASS");
        end else begin
            $display("filter2d_correlation_same_top_test: FAIL");
        end
        $finish;
    end

    // run limit
    initial begin
        #20_000_000;
        $display("filter2d_correlation_same_top_test: FAIL");
        $finish;
    end

endmodule

FILE: files.f
rtl/f2dc_pkg.sv
rtl/f2dc_line_buf.sv
rtl/f2dc_ctrl.sv
rtl/f2dc_mac.sv
rtl/filter2d_correlation_same_top.sv
verif/filter2d_correlation_same_top_test.sv
